>>> rtl/fpbs_pkg.sv
// ----------------------------------------------------------------------------
// fpbs_pkg
// shared types and constants of the fixed-pattern byte search
// ----------------------------------------------------------------------------
package fpbs_pkg;

   // field and register widths
   localparam int BYTE_WIDTH          = 8;
   localparam int WORD_WIDTH          = 64;
   localparam int LEN_REG_WIDTH       = 6;
   localparam int LEN_WIDTH           = LEN_REG_WIDTH + 1;
   localparam int REG_BYTES           = 32;
   localparam int REG_BYTE_IDX_WIDTH  = 5;
   localparam int PATTERN_WORDS       = 4;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int OUT_OFFSET_WIDTH    = 20;
   localparam int RSP_DATA_WIDTH      = 24;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_PATTERN_LENGTH = 3'd0,
      REG_PATTERN_WORD_0 = 3'd1,
      REG_PATTERN_WORD_1 = 3'd2,
      REG_PATTERN_WORD_2 = 3'd3,
      REG_PATTERN_WORD_3 = 3'd4
   } csr_reg_type;

   // control handed from the top level to every window cell
   typedef struct packed {
      logic advance;   // a text beat is taken, shift the window
      logic clear;     // the beat ends the text, window restarts empty
   } cell_ctrl_type;

endpackage

>>> rtl/fpbs_cell.sv
// ----------------------------------------------------------------------------
// fpbs_cell
// one window position: holds a text byte, passes it on, compares the byte
// that moves in with its aligned pattern byte
// ----------------------------------------------------------------------------
module fpbs_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  fpbs_pkg::cell_ctrl_type          ctrl,
   input  logic [fpbs_pkg::BYTE_WIDTH-1:0]  byte_in,
   input  logic [fpbs_pkg::BYTE_WIDTH-1:0]  pattern_byte,
   input  logic                             enable,
   output logic [fpbs_pkg::BYTE_WIDTH-1:0]  byte_out,
   output logic                             match
);
   import fpbs_pkg::*;

   logic [BYTE_WIDTH-1:0] window_ff;
   logic [BYTE_WIDTH-1:0] window_in;

   // next window byte, cleared when the text ends
   assign window_in = ctrl.clear ? '0 : byte_in;

   // a position outside the pattern always agrees
   assign match    = !enable || (byte_in == pattern_byte);
   assign byte_out = window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (ctrl.advance) begin
         window_ff <= window_in;
      end
   end

endmodule

>>> rtl/fixed_pattern_byte_search.sv
// ----------------------------------------------------------------------------
// fixed_pattern_byte_search
// leftmost search for a configured byte pattern in a streamed text
// ----------------------------------------------------------------------------
// The block takes one text byte per clock cycle and checks every alignment
// against a pattern of up to MAX_PATTERN bytes held in configuration
// registers. A row of window cells shifts the text along and compares all
// positions in parallel in the cycle the byte is taken, so a result is
// registered and appears in the cycle after its byte. At most one result
// leaves per text: found with the start offset on the first full match, or
// not found on the last byte. req_tready drops only while a result sits in
// the output register and rsp_tready is low. The offset saturates at
// 2^OFFSET_WIDTH - 1 and the output carries its low 20 bits. Configuration
// writes take effect from the next byte on.
module fixed_pattern_byte_search #(
   parameter int MAX_PATTERN  = 32,
   parameter int OFFSET_WIDTH = 20
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // text beats
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [fpbs_pkg::BYTE_WIDTH-1:0]        req_tdata,   // [7:0] text_byte
   input  logic                                   req_tlast,   // last_byte
   // result beats
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [fpbs_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,   // [19:0] match_offset
   output logic [0:0]                             rsp_tuser,   // [0] found
   // configuration writes
   input  logic                                   csr_we,
   input  logic [fpbs_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [fpbs_pkg::WORD_WIDTH-1:0]        csr_wdata
);
   import fpbs_pkg::*;

   localparam int WIDE_WIDTH = OUT_OFFSET_WIDTH + OFFSET_WIDTH;

   // configuration registers
   logic [LEN_REG_WIDTH-1:0]  pattern_length_ff;
   logic [WORD_WIDTH-1:0]     pattern_word_ff [PATTERN_WORDS];
   logic [REG_BYTES*BYTE_WIDTH-1:0] pattern_flat;

   // search state
   logic [OFFSET_WIDTH-1:0]   count_ff;
   logic [OFFSET_WIDTH-1:0]   count_in;
   logic                      done_ff;
   logic                      done_in;

   // output register
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic                         found_ff;
   logic                         found_in;
   logic [OUT_OFFSET_WIDTH-1:0]  offset_ff;
   logic [OUT_OFFSET_WIDTH-1:0]  offset_in;

   // datapath
   logic [LEN_WIDTH-1:0]      len_raw;
   logic [LEN_WIDTH-1:0]      len;
   logic [OFFSET_WIDTH-1:0]   len_cnt;
   logic                      saturated;
   logic [OFFSET_WIDTH-1:0]   total;
   logic [OFFSET_WIDTH-1:0]   start;
   logic [WIDE_WIDTH-1:0]     start_wide;
   logic                      too_few;
   logic                      hit;
   logic                      accept;
   logic                      emit;
   cell_ctrl_type             cell_ctrl;
   logic [BYTE_WIDTH-1:0]     window [MAX_PATTERN];
   logic [MAX_PATTERN-1:0]    match_vec;

   // configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         for (int i = 0; i < PATTERN_WORDS; i++) begin
            pattern_word_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            REG_PATTERN_LENGTH: pattern_length_ff  <= csr_wdata[LEN_REG_WIDTH-1:0];
            REG_PATTERN_WORD_0: pattern_word_ff[0] <= csr_wdata;
            REG_PATTERN_WORD_1: pattern_word_ff[1] <= csr_wdata;
            REG_PATTERN_WORD_2: pattern_word_ff[2] <= csr_wdata;
            REG_PATTERN_WORD_3: pattern_word_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign pattern_flat = {pattern_word_ff[3], pattern_word_ff[2],
                          pattern_word_ff[1], pattern_word_ff[0]};

   // effective pattern length, capped at the window depth
   assign len_raw = {1'b0, pattern_length_ff};
   assign len     = (len_raw > LEN_WIDTH'(MAX_PATTERN)) ? LEN_WIDTH'(MAX_PATTERN) : len_raw;
   assign len_cnt = OFFSET_WIDTH'(len);

   // handshake
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cell_ctrl  = '{advance: accept, clear: req_tlast};

   // row of window cells, newest byte at position 0
   for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
      localparam logic [LEN_WIDTH-1:0] CELL_POS = LEN_WIDTH'(g);
      logic [LEN_WIDTH-1:0]  pat_idx;
      logic [BYTE_WIDTH-1:0] pat_byte;
      logic [BYTE_WIDTH-1:0] cell_in;
      logic                  cell_en;

      // pattern byte that lines up with this position
      assign pat_idx  = len - CELL_POS - LEN_WIDTH'(1);
      assign cell_en  = CELL_POS < len;
      assign pat_byte = (pat_idx < LEN_WIDTH'(REG_BYTES))
                      ? pattern_flat[{pat_idx[REG_BYTE_IDX_WIDTH-1:0], 3'b000} +: BYTE_WIDTH]
                      : '0;

      if (g == 0) begin : g_head
         assign cell_in = req_tdata;
      end else begin : g_body
         assign cell_in = window[g-1];
      end

      fpbs_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl),
         .byte_in      (cell_in),
         .pattern_byte (pat_byte),
         .enable       (cell_en),
         .byte_out     (window[g]),
         .match        (match_vec[g])
      );
   end

   // byte count and match decision
   always_comb begin
      saturated  = &count_ff;
      total      = saturated ? count_ff : count_ff + OFFSET_WIDTH'(1);
      too_few    = !saturated && (total < len_cnt);
      hit        = (len == '0) || (!too_few && (&match_vec));
      start      = (len == '0) ? '0 : (saturated ? count_ff : total - len_cnt);
      start_wide = WIDE_WIDTH'(start);
      emit       = accept && !done_ff && (hit || req_tlast);
      found_in   = hit;
      offset_in  = hit ? start_wide[OUT_OFFSET_WIDTH-1:0] : '0;
   end

   // next search state
   always_comb begin
      count_in = count_ff;
      done_in  = done_ff;
      if (accept) begin
         count_in = req_tlast ? '0 : total;
         done_in  = req_tlast ? 1'b0 : (done_ff || hit);
      end
   end

   // output valid
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         found_ff  <= found_in;
         offset_ff <= offset_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH-OUT_OFFSET_WIDTH){1'b0}}, offset_ff};
   assign rsp_tuser  = found_ff;

   // not-found results carry a zero offset
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("not-found result with nonzero offset");

   // the last byte restarts the search
   a_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> count_ff == '0 && !done_ff)
      else $error("search not restarted after last byte");

   // no further result once a match was reported in this text
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      accept && done_ff && !req_tlast |=> !rsp_tvalid)
      else $error("extra result after match");

   // an empty pattern matches at offset zero on the next byte
   a_empty_pattern: assert property (@(posedge clock) disable iff (reset)
      accept && !done_ff && pattern_length_ff == '0
      |=> rsp_tvalid && rsp_tuser[0] && rsp_tdata == '0)
      else $error("empty pattern did not match at offset zero");

   // input stalls only behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a waiting result");

endmodule
